FILE: design/prr_pkg.sv
// Package for the planar reprojection residual block.
// Holds word formats, register indexes, CORDIC constants and the arctangent table.
// Used by every file in the design folder except prr_if.
`timescale 1ns / 1ps

package prr_pkg;

  // Default word format, signed fixed point.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Configuration register widths and port format.
  localparam int FOCAL_W    = 31;
  localparam int RADIAL_W   = 32;
  localparam int ANGLE_W    = 19;
  localparam int DEPTH_W    = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL  = 2'd0,
    CFG_RADIAL = 2'd1,
    CFG_ANGLE  = 2'd2,
    CFG_DEPTH  = 2'd3
  } cfg_idx_t;

  // Trigonometric format: Q2.30.
  localparam int TRIG_FRAC    = 30;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_XY_W  = 33;
  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam longint HALF_PI_T   = 64'd1686629713;
  localparam longint PI_T        = 64'd3373259426;

  // Sequencer states of the sine and cosine unit.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_ROT
  } cordic_state_t;

  // Angle step of CORDIC iteration i, in Q2.30.
  function automatic logic [31:0] cordic_step(input logic [4:0] i);
    logic [31:0] s;
    case (i)
      5'd0:    s = 32'd843314857;
      5'd1:    s = 32'd497837829;
      5'd2:    s = 32'd263043837;
      5'd3:    s = 32'd133525159;
      5'd4:    s = 32'd67021687;
      5'd5:    s = 32'd33543516;
      5'd6:    s = 32'd16775851;
      5'd7:    s = 32'd8388437;
      5'd8:    s = 32'd4194283;
      5'd9:    s = 32'd2097149;
      default: s = 32'd1 << (5'(TRIG_FRAC) - i);
    endcase
    return s;
  endfunction

endpackage

FILE: design/prr_if.sv
// Handshake channels of the planar reprojection residual block.
// Observation words in, result words out; widths follow the word size.
`timescale 1ns / 1ps

interface prr_obs_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] cam_x;
  logic signed [W-1:0] cam_y;
  logic signed [W-1:0] key_x;
  logic signed [W-1:0] key_y;
  logic signed [W-1:0] observed_u;
  logic signed [W-1:0] observed_v;

  modport source (output valid, cam_x, cam_y, key_x, key_y, observed_u, observed_v,
                  input ready);
  modport sink (input valid, cam_x, cam_y, key_x, key_y, observed_u, observed_v,
                output ready);
endinterface

interface prr_res_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pred_u;
  logic signed [W-1:0] pred_v;
  logic signed [W-1:0] resid_u;
  logic signed [W-1:0] resid_v;
  logic                saturated;

  modport source (output valid, pred_u, pred_v, resid_u, resid_v, saturated,
                  input ready);
  modport sink (input valid, pred_u, pred_v, resid_u, resid_v, saturated,
                output ready);
endinterface

FILE: design/prr_cordic.sv
// Iterative sine and cosine unit: one CORDIC step per cycle, Q2.30 results.
// Depends on prr_pkg for the constants, the step table and the state type.
`timescale 1ns / 1ps

module prr_cordic #(
  parameter int FRAC_BITS = prr_pkg::FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic signed [prr_pkg::ANGLE_W-1:0] angle,
  output logic signed [prr_pkg::TRIG_W-1:0]  cos_q,
  output logic signed [prr_pkg::TRIG_W-1:0]  sin_q,
  output logic                               busy
);
  import prr_pkg::*;

  localparam int SH    = TRIG_FRAC - FRAC_BITS;
  localparam int A_RAW = ANGLE_W + SH + 2;
  localparam int A_W   = (A_RAW > 35) ? A_RAW : 35;

  cordic_state_t state, state_next;

  logic signed [A_W-1:0]         acc;
  logic signed [CORDIC_XY_W-1:0] x, y;
  logic [4:0]                    step;
  logic                          flip;

  logic signed [A_W-1:0]         a_ext;
  logic signed [CORDIC_XY_W-1:0] dx, dy, x_new, y_new;
  logic signed [A_W-1:0]         da;
  logic                          last;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign last = (step == 5'(CORDIC_STEPS - 1));

  // Next state: a load restarts the sequence from any state.
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: state_next = CS_IDLE;
      CS_LOAD: state_next = CS_ROT;
      CS_ROT:  state_next = last ? CS_IDLE : CS_ROT;
      default: state_next = CS_IDLE;
    endcase
    if (load) begin
      state_next = CS_LOAD;
    end
  end

  assign busy = (state != CS_IDLE);

  // One rotation step.
  always_comb begin
    a_ext = A_W'(angle) <<< SH;
    dx    = y >>> step;
    dy    = x >>> step;
    da    = A_W'(cordic_step(step));
    if (acc >= 0) begin
      x_new = x - dx;
      y_new = y + dy;
    end else begin
      x_new = x + dx;
      y_new = y - dy;
    end
  end

  // Angle reduction, iteration and the final quadrant correction.
  always_ff @(posedge clk) begin
    if (state == CS_LOAD) begin
      x    <= CORDIC_XY_W'(CORDIC_GAIN);
      y    <= '0;
      step <= '0;
      if (a_ext > A_W'(HALF_PI_T)) begin
        acc  <= a_ext - A_W'(PI_T);
        flip <= 1'b1;
      end else if (a_ext < -A_W'(HALF_PI_T)) begin
        acc  <= a_ext + A_W'(PI_T);
        flip <= 1'b1;
      end else begin
        acc  <= a_ext;
        flip <= 1'b0;
      end
    end else if (state == CS_ROT) begin
      x    <= x_new;
      y    <= y_new;
      step <= step + 5'd1;
      acc  <= (acc >= 0) ? acc - da : acc + da;
      if (last) begin
        cos_q <= flip ? TRIG_W'(-x_new) : TRIG_W'(x_new);
        sin_q <= flip ? TRIG_W'(-y_new) : TRIG_W'(y_new);
      end
    end
  end

endmodule

FILE: design/prr_mulq.sv
// Two-stage fixed-point multiplier: magnitude product, then rounding and clipping.
// Rounds to nearest with ties away from zero; depends on prr_pkg only by convention.
`timescale 1ns / 1ps

module prr_mulq #(
  parameter int AW    = 32,
  parameter int BW    = 32,
  parameter int W     = 32,
  parameter int SHIFT = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  input  logic                 sat_i,
  output logic signed [W-1:0]  q,
  output logic                 sat_o
);
  import prr_pkg::*;

  localparam int PW = AW + BW;
  localparam int RW = PW + 1 - SHIFT;
  localparam int CW = (RW > W) ? RW : W;

  logic [AW-1:0] ua;
  logic [BW-1:0] ub;
  logic [PW-1:0] prod;
  logic          neg1, sat1;

  logic [PW:0]   rnd;
  logic [CW-1:0] qm, lim, qs;
  logic          over;

  assign ua = a[AW-1] ? AW'(-a) : AW'(a);
  assign ub = b[BW-1] ? BW'(-b) : BW'(b);

  // Stage one: product of the magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(ua) * PW'(ub);
      neg1 <= a[AW-1] ^ b[BW-1];
      sat1 <= sat_i;
    end
  end

  // Round, shift and clip against the word range of the sign.
  always_comb begin
    rnd  = {1'b0, prod} + ((PW + 1)'(1) << (SHIFT - 1));
    qm   = CW'(rnd[PW:SHIFT]);
    lim  = neg1 ? (CW'(1) << (W - 1)) : ((CW'(1) << (W - 1)) - CW'(1));
    over = (qm > lim);
    qs   = over ? lim : qm;
  end

  // Stage two: signed result.
  always_ff @(posedge clk) begin
    if (en) begin
      q     <= neg1 ? -W'(qs) : W'(qs);
      sat_o <= sat1 | over;
    end
  end

endmodule

FILE: design/prr_div.sv
// Pipelined restoring divider: (num << F) / den, one quotient bit a stage.
// Rounds to nearest and clips to the word range; den must be non-zero.
`timescale 1ns / 1ps

module prr_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int DW = 31
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] num,
  input  logic [DW-1:0]       den,
  input  logic                sat_i,
  output logic signed [W-1:0] q,
  output logic                sat_o
);
  import prr_pkg::*;

  localparam int N  = W + F;
  localparam int CW = N + 1;

  logic [DW-1:0] rem [0:N];
  logic [N-1:0]  dvd [0:N];
  logic [N-1:0]  quo [0:N];
  logic          neg [0:N];
  logic          sat [0:N];

  logic [W-1:0]  mag;
  logic [CW-1:0] q1, lim, qs;
  logic          rnd, over;

  assign mag = num[W-1] ? W'(-num) : W'(num);

  // Entry stage: magnitude of the dividend, fraction bits appended.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dvd[0] <= {mag, {F{1'b0}}};
      quo[0] <= '0;
      neg[0] <= num[W-1];
      sat[0] <= sat_i;
    end
  end

  // One trial subtraction per stage.
  for (genvar k = 0; k < N; k++) begin : g_bit
    logic [DW:0] trial;
    logic        take;

    assign trial = {rem[k], dvd[k][N-1]};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? DW'(trial - {1'b0, den}) : DW'(trial);
        dvd[k+1] <= dvd[k] << 1;
        quo[k+1] <= {quo[k][N-2:0], take};
        neg[k+1] <= neg[k];
        sat[k+1] <= sat[k];
      end
    end
  end

  // Rounding from the remainder, then clipping.
  always_comb begin
    rnd  = ({rem[N], 1'b0} >= {1'b0, den});
    q1   = CW'(quo[N]) + CW'(rnd);
    lim  = neg[N] ? (CW'(1) << (W - 1)) : ((CW'(1) << (W - 1)) - CW'(1));
    over = (q1 > lim);
    qs   = over ? lim : q1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q     <= neg[N] ? -W'(qs) : W'(qs);
      sat_o <= sat[N] | over;
    end
  end

endmodule

FILE: design/prr_delay.sv
// Stallable delay line that carries side data alongside the arithmetic stages.
// Imports prr_pkg but uses nothing from it.
`timescale 1ns / 1ps

module prr_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  import prr_pkg::*;

  logic [WIDTH-1:0] tap [0:DEPTH-1];

  // Shift one place whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

FILE: design/planar_reprojection_residual.sv
// Top level of the planar reprojection residual pipeline.
// Uses prr_pkg, prr_if, prr_cordic, prr_mulq, prr_div and prr_delay.
//
// Usage:
//   obs carries one observation word per handshake: camera position, keypoint
//   and observed image point. res returns one result word per observation:
//   predicted point, residual and a flag that is set when any value clipped.
//   The camera is set through cfg_we, cfg_index and cfg_data while idle.
// Throughput: one word per cycle once running, while res takes results and the sine and cosine unit is idle.
// Pipeline: the bit-per-stage divider makes up most of its stages.
// Reset: registers return to focal 1.0, no distortion, angle 0, depth 1.0.
//   The sine and cosine unit then runs its load and rotation steps, during which
//   obs.ready is low; every write of the angle repeats that run.
// Stalls: when res is not taken, the whole pipeline holds and obs.ready drops;
//   nothing is lost or repeated.
`timescale 1ns / 1ps

module planar_reprojection_residual #(
  parameter int WORD_BITS = prr_pkg::WORD_BITS,
  parameter int FRAC_BITS = prr_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [prr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prr_pkg::CFG_DATA_W-1:0] cfg_data,
  prr_obs_if.sink                        obs,
  prr_res_if.source                      res
);
  import prr_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int DIV_L = W + FRAC_BITS + 2;
  localparam int T_X   = 4 + DIV_L;
  localparam int LAST  = T_X + 11;

  // Clip a sum one bit wider than a word; the top bit of the result flags it.
  function automatic logic [W:0] clamp_w(input logic signed [W:0] s);
    logic [W:0] r;
    if (s[W] != s[W-1]) begin
      r = {1'b1, s[W], {(W-1){~s[W]}}};
    end else begin
      r = {1'b0, s[W-1:0]};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [FOCAL_W-1:0]         focal_length;
  logic signed [RADIAL_W-1:0] radial_coeff;
  logic signed [ANGLE_W-1:0]  rotation_angle;
  logic [DEPTH_W-1:0]         scene_depth;
  logic [DEPTH_W-1:0]         depth_eff;
  logic                       angle_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length   <= FOCAL_W'(1) << FRAC_BITS;
      radial_coeff   <= '0;
      rotation_angle <= '0;
      scene_depth    <= DEPTH_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FOCAL:  focal_length   <= cfg_data[FOCAL_W-1:0];
        CFG_RADIAL: radial_coeff   <= cfg_data[RADIAL_W-1:0];
        CFG_ANGLE:  rotation_angle <= cfg_data[ANGLE_W-1:0];
        CFG_DEPTH:  scene_depth    <= cfg_data[DEPTH_W-1:0];
        default:    focal_length   <= focal_length;
      endcase
    end
  end

  assign angle_load = cfg_we && (cfg_idx_t'(cfg_index) == CFG_ANGLE);
  assign depth_eff  = (scene_depth == '0) ? DEPTH_W'(1) : scene_depth;

  // Sine and cosine of the camera angle.
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                     trig_busy;

  prr_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .load  (angle_load),
    .angle (rotation_angle),
    .cos_q (cos_q),
    .sin_q (sin_q),
    .busy  (trig_busy)
  );

  // Pipeline control: every stage moves together.
  logic [LAST:0] vld;
  logic          en;

  assign en        = !vld[LAST] || res.ready;
  assign obs.ready = en && !trig_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], obs.valid && obs.ready};
    end
  end

  // Stage 0: input word.
  logic signed [W-1:0] cx0, cy0, kx0, ky0, ou0, ov0;

  always_ff @(posedge clk) begin
    if (en) begin
      cx0 <= obs.cam_x;
      cy0 <= obs.cam_y;
      kx0 <= obs.key_x;
      ky0 <= obs.key_y;
      ou0 <= obs.observed_u;
      ov0 <= obs.observed_v;
    end
  end

  // Rotation products, ready at stage 2.
  logic signed [W-1:0] m_kxc, m_kys, m_kxs, m_kyc;
  logic                f_kxc, f_kys, f_kxs, f_kyc;

  prr_mulq #(.AW(W), .BW(TRIG_W), .W(W), .SHIFT(TRIG_FRAC)) u_mul_kxc (
    .clk(clk), .en(en), .a(kx0), .b(cos_q), .sat_i(1'b0), .q(m_kxc), .sat_o(f_kxc));
  prr_mulq #(.AW(W), .BW(TRIG_W), .W(W), .SHIFT(TRIG_FRAC)) u_mul_kys (
    .clk(clk), .en(en), .a(ky0), .b(sin_q), .sat_i(1'b0), .q(m_kys), .sat_o(f_kys));
  prr_mulq #(.AW(W), .BW(TRIG_W), .W(W), .SHIFT(TRIG_FRAC)) u_mul_kxs (
    .clk(clk), .en(en), .a(kx0), .b(sin_q), .sat_i(1'b0), .q(m_kxs), .sat_o(f_kxs));
  prr_mulq #(.AW(W), .BW(TRIG_W), .W(W), .SHIFT(TRIG_FRAC)) u_mul_kyc (
    .clk(clk), .en(en), .a(ky0), .b(cos_q), .sat_i(1'b0), .q(m_kyc), .sat_o(f_kyc));

  // Stage 3: rotated keypoint.
  logic signed [W-1:0] rx3, ry3;
  logic                sat3;
  logic [W:0]          c_rx, c_ry;

  assign c_rx = clamp_w((W+1)'(m_kxc) - (W+1)'(m_kys));
  assign c_ry = clamp_w((W+1)'(m_kxs) + (W+1)'(m_kyc));

  always_ff @(posedge clk) begin
    if (en) begin
      rx3  <= c_rx[W-1:0];
      ry3  <= c_ry[W-1:0];
      sat3 <= f_kxc | f_kys | f_kxs | f_kyc | c_rx[W] | c_ry[W];
    end
  end

  // Camera position delayed to stage 3.
  logic [2*W-1:0]      cam3;
  logic signed [W-1:0] cx3, cy3;

  prr_delay #(.WIDTH(2*W), .DEPTH(3)) u_dly_cam (
    .clk(clk), .en(en), .d({cx0, cy0}), .q(cam3));

  assign cx3 = cam3[2*W-1:W];
  assign cy3 = cam3[W-1:0];

  // Stage 4: point in camera frame.
  logic signed [W-1:0] px4, py4;
  logic                sat4;
  logic [W:0]          c_px, c_py;

  assign c_px = clamp_w((W+1)'(rx3) + (W+1)'(cx3));
  assign c_py = clamp_w((W+1)'(ry3) + (W+1)'(cy3));

  always_ff @(posedge clk) begin
    if (en) begin
      px4  <= c_px[W-1:0];
      py4  <= c_py[W-1:0];
      sat4 <= sat3 | c_px[W] | c_py[W];
    end
  end

  // Perspective division by the depth.
  logic signed [W-1:0] xp, yp;
  logic                f_xp, f_yp;

  prr_div #(.W(W), .F(FRAC_BITS), .DW(DEPTH_W)) u_div_x (
    .clk(clk), .en(en), .num(px4), .den(depth_eff), .sat_i(sat4), .q(xp), .sat_o(f_xp));
  prr_div #(.W(W), .F(FRAC_BITS), .DW(DEPTH_W)) u_div_y (
    .clk(clk), .en(en), .num(py4), .den(depth_eff), .sat_i(1'b0), .q(yp), .sat_o(f_yp));

  // Squared radius terms.
  logic signed [W-1:0] m_xx, m_yy;
  logic                f_xx, f_yy;

  prr_mulq #(.AW(W), .BW(W), .W(W), .SHIFT(FRAC_BITS)) u_mul_xx (
    .clk(clk), .en(en), .a(xp), .b(xp), .sat_i(f_xp), .q(m_xx), .sat_o(f_xx));
  prr_mulq #(.AW(W), .BW(W), .W(W), .SHIFT(FRAC_BITS)) u_mul_yy (
    .clk(clk), .en(en), .a(yp), .b(yp), .sat_i(f_yp), .q(m_yy), .sat_o(f_yy));

  logic signed [W-1:0] r2;
  logic                sat_r2;
  logic [W:0]          c_r2;

  assign c_r2 = clamp_w((W+1)'(m_xx) + (W+1)'(m_yy));

  always_ff @(posedge clk) begin
    if (en) begin
      r2     <= c_r2[W-1:0];
      sat_r2 <= f_xx | f_yy | c_r2[W];
    end
  end

  // Distortion factor 1 + k * r^2.
  logic signed [W-1:0] m_rk;
  logic                f_rk;

  prr_mulq #(.AW(W), .BW(RADIAL_W), .W(W), .SHIFT(FRAC_BITS)) u_mul_rk (
    .clk(clk), .en(en), .a(r2), .b(radial_coeff), .sat_i(sat_r2), .q(m_rk), .sat_o(f_rk));

  logic signed [W-1:0] distort;
  logic                sat_dist;
  logic [W:0]          c_dist;

  assign c_dist = clamp_w(((W+1)'(1) << FRAC_BITS) + (W+1)'(m_rk));

  always_ff @(posedge clk) begin
    if (en) begin
      distort  <= c_dist[W-1:0];
      sat_dist <= f_rk | c_dist[W];
    end
  end

  // Focal scale times distortion.
  logic signed [W-1:0] m_fd;
  logic                f_fd;

  prr_mulq #(.AW(FOCAL_W + 1), .BW(W), .W(W), .SHIFT(FRAC_BITS)) u_mul_fd (
    .clk(clk), .en(en), .a({1'b0, focal_length}), .b(distort), .sat_i(sat_dist),
    .q(m_fd), .sat_o(f_fd));

  // Normalised point delayed to meet the scale.
  logic [2*W-1:0]      xy_d;
  logic signed [W-1:0] xp_d, yp_d;

  prr_delay #(.WIDTH(2*W), .DEPTH(8)) u_dly_xy (
    .clk(clk), .en(en), .d({xp, yp}), .q(xy_d));

  assign xp_d = xy_d[2*W-1:W];
  assign yp_d = xy_d[W-1:0];

  // Predicted image point.
  logic signed [W-1:0] m_pu, m_pv;
  logic                f_pu, f_pv;

  prr_mulq #(.AW(W), .BW(W), .W(W), .SHIFT(FRAC_BITS)) u_mul_pu (
    .clk(clk), .en(en), .a(m_fd), .b(xp_d), .sat_i(f_fd), .q(m_pu), .sat_o(f_pu));
  prr_mulq #(.AW(W), .BW(W), .W(W), .SHIFT(FRAC_BITS)) u_mul_pv (
    .clk(clk), .en(en), .a(m_fd), .b(yp_d), .sat_i(1'b0), .q(m_pv), .sat_o(f_pv));

  // Observed point delayed to the residual stage.
  logic [2*W-1:0]      obs_d;
  logic signed [W-1:0] ou_d, ov_d;

  prr_delay #(.WIDTH(2*W), .DEPTH(T_X + 10)) u_dly_obs (
    .clk(clk), .en(en), .d({ou0, ov0}), .q(obs_d));

  assign ou_d = obs_d[2*W-1:W];
  assign ov_d = obs_d[W-1:0];

  // Output register: predicted point, residuals and the clip flag.
  logic [W:0] c_ru, c_rv;

  assign c_ru = clamp_w((W+1)'(m_pu) - (W+1)'(ou_d));
  assign c_rv = clamp_w((W+1)'(m_pv) - (W+1)'(ov_d));

  always_ff @(posedge clk) begin
    if (en) begin
      res.pred_u    <= m_pu;
      res.pred_v    <= m_pv;
      res.resid_u   <= c_ru[W-1:0];
      res.resid_v   <= c_rv[W-1:0];
      res.saturated <= f_pu | f_pv | c_ru[W] | c_rv[W];
    end
  end

  assign res.valid = vld[LAST];

endmodule
